### rtl/core/mal_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the mix accumulator with adaptive limiter.
// No dependencies; every other file of the block refers to this package by scoped names.
package mal_pkg;

  localparam int unsigned PART_W    = 24;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned REG_W     = 25;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned Q_DEPTH   = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FLOOR     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RISE_STEP = CFG_IDX_W'(1);

  localparam logic [REG_W-1:0] GAIN_FLOOR_RST     = REG_W'(3355443);
  localparam logic [REG_W-1:0] GAIN_RISE_STEP_RST = REG_W'(336);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Finished frame sums handed from the front to the back
  typedef struct packed {
    logic signed [SUM_W-1:0] left_sum;
    logic signed [SUM_W-1:0] right_sum;
  } sum_pair_t;

  typedef struct packed {
    logic [REG_W-1:0] gain_floor;
    logic [REG_W-1:0] gain_rise_step;
  } cfg_t;

  // Saturating add of one contribution into a 32-bit accumulator
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]  acc,
    input logic signed [PART_W-1:0] part
  );
    logic signed [SUM_W:0] wide;
    wide = {acc[SUM_W-1], acc} + (SUM_W+1)'(part);
    if (wide > (SUM_W+1)'(SUM_MAX)) begin
      return SUM_MAX;
    end else if (wide < (SUM_W+1)'(SUM_MIN)) begin
      return SUM_MIN;
    end
    return wide[SUM_W-1:0];
  endfunction

endpackage

### rtl/core/mix_accumulate_adaptive_limiter.sv
`timescale 1ns / 1ps
// Top level of the mix accumulator with adaptive limiter: config registers and wiring.
// Depends on mal_pkg, mal_front, mal_queue and mal_back.
//
// Each input transfer adds one panned stereo contribution into saturating 32-bit
// left and right sums; a transfer with frame_end_i set closes the frame, and one
// output transfer follows carrying both sums scaled by the current Q(GAIN_FRAC_BITS)
// gain (truncated toward zero), clamped to 16 bits, with clipped_o flagging any
// clamp. The gain drops by one hundredth while a scaled sample leaves 16-bit range
// and the gain sits above gain_floor, and climbs by gain_rise_step up to unity
// while the sample stays in range; left is judged before right. The block takes one
// input transfer every cycle while the queue has room and can deliver one frame
// every cycle while out_ready_i is high: the gain loop (magnitude, one 32 x
// (GAIN_FRAC_BITS+1) multiply per channel, two chained gain updates) is
// combinational. A frame result passes the queue and the output register before it
// shows. A two-entry queue of finished frames separates the accumulating front from
// the scaling back, so in_ready_o drops only after the output has stalled with two
// further frames waiting. Configuration writes are always taken (cfg_ready_o is
// high); an index beyond gain_rise_step is ignored, and writes leave the gain alone.
module mix_accumulate_adaptive_limiter #(
  parameter int unsigned GAIN_FRAC_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // contribution channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [mal_pkg::PART_W-1:0]    left_part_i,
  input  logic signed [mal_pkg::PART_W-1:0]    right_part_i,
  input  logic                                 frame_end_i,
  // output sample channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [mal_pkg::OUT_W-1:0]     left_out_o,
  output logic signed [mal_pkg::OUT_W-1:0]     right_out_o,
  output logic                                 clipped_o,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mal_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [mal_pkg::REG_W-1:0]            cfg_data_i
);

  mal_pkg::cfg_t      cfg_q, cfg_d;
  logic               q_full, q_valid, push, pop;
  mal_pkg::sum_pair_t push_data, q_data;

  // Configuration registers: decode the index, drop unknown ones
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mal_pkg::REG_GAIN_FLOOR:     cfg_d.gain_floor     = cfg_data_i;
        mal_pkg::REG_GAIN_RISE_STEP: cfg_d.gain_rise_step = cfg_data_i;
        default:                     cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_floor     <= mal_pkg::GAIN_FLOOR_RST;
      cfg_q.gain_rise_step <= mal_pkg::GAIN_RISE_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accumulate contributions, push each finished frame
  mal_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .left_part_i  (left_part_i),
    .right_part_i (right_part_i),
    .frame_end_i  (frame_end_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // Hold finished frames until the back can take them
  mal_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (pop)
  );

  // Back: scale, adapt gain, clamp, register the result
  mal_back #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .clipped_o   (clipped_o)
  );

endmodule

### rtl/core/mal_front.sv
`timescale 1ns / 1ps
// Front end: takes contributions and keeps the saturating left/right accumulators.
// Depends on mal_pkg; pushes finished frame sums into mal_queue.
module mal_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [mal_pkg::PART_W-1:0] left_part_i,
  input  logic signed [mal_pkg::PART_W-1:0] right_part_i,
  input  logic                              frame_end_i,
  input  logic                              q_full_i,
  output logic                              push_o,
  output mal_pkg::sum_pair_t                push_data_o
);

  logic signed [mal_pkg::SUM_W-1:0] left_sum_q, left_sum_d;
  logic signed [mal_pkg::SUM_W-1:0] right_sum_q, right_sum_d;
  logic                             accept;
  logic signed [mal_pkg::SUM_W-1:0] left_new, right_new;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign left_new  = mal_pkg::sat_add(left_sum_q, left_part_i);
  assign right_new = mal_pkg::sat_add(right_sum_q, right_part_i);

  assign push_o                = accept && frame_end_i;
  assign push_data_o.left_sum  = left_new;
  assign push_data_o.right_sum = right_new;

  always_comb begin
    left_sum_d  = left_sum_q;
    right_sum_d = right_sum_q;
    if (accept) begin
      // clear on frame end, the finished sums travel through the queue
      left_sum_d  = frame_end_i ? '0 : left_new;
      right_sum_d = frame_end_i ? '0 : right_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_sum_q  <= '0;
      right_sum_q <= '0;
    end else begin
      left_sum_q  <= left_sum_d;
      right_sum_q <= right_sum_d;
    end
  end

endmodule

### rtl/core/mal_queue.sv
`timescale 1ns / 1ps
// Short FIFO of finished frame sums between the front and the back.
// Depends on mal_pkg for the entry type and depth.
module mal_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mal_pkg::sum_pair_t push_data_i,
  output logic               full_o,
  output logic               valid_o,
  output mal_pkg::sum_pair_t data_o,
  input  logic               pop_i
);

  localparam int unsigned PTR_W = (mal_pkg::Q_DEPTH > 1) ? $clog2(mal_pkg::Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(mal_pkg::Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(mal_pkg::Q_DEPTH - 1);

  mal_pkg::sum_pair_t entry_q [mal_pkg::Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == CNT_W'(mal_pkg::Q_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/core/mal_back.sv
`timescale 1ns / 1ps
// Back end: scales a finished frame by the gain, adapts the gain, clamps to 16 bits.
// Depends on mal_pkg; drains mal_queue and drives the registered output channel.
module mal_back #(
  parameter int unsigned GAIN_FRAC_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mal_pkg::cfg_t                    cfg_i,
  input  logic                             q_valid_i,
  input  mal_pkg::sum_pair_t               q_data_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [mal_pkg::OUT_W-1:0] left_out_o,
  output logic signed [mal_pkg::OUT_W-1:0] right_out_o,
  output logic                             clipped_o
);

  localparam int unsigned SW = mal_pkg::SUM_W;
  localparam int unsigned OW = mal_pkg::OUT_W;
  localparam int unsigned GW = GAIN_FRAC_BITS + 1;
  localparam int unsigned AW = ((GW > mal_pkg::REG_W) ? GW : mal_pkg::REG_W) + 1;
  localparam int unsigned PW = SW + GW;

  localparam logic [GW-1:0] GAIN_UNITY = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
  localparam logic [GW-1:0] GAIN_DROP  =
    GW'(((64'd1 << GAIN_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [SW-1:0] NEG_LIMIT  = SW'(1) << (OW - 1);

  typedef struct packed {
    logic               over;
    logic [OW-1:0]      value;
  } chan_t;

  logic [GW-1:0]  gain_q, gain_d, gain_mid;
  logic           out_valid_q;
  logic [OW-1:0]  left_q, right_q;
  logic           clip_q;
  chan_t          left_c, right_c;

  function automatic chan_t scale_clamp(
    input logic signed [SW-1:0] sum,
    input logic [GW-1:0]        g
  );
    logic          neg;
    logic [SW-1:0] mag;
    logic [PW-1:0] prod;
    logic [SW-1:0] p;
    chan_t         c;
    neg  = sum[SW-1];
    mag  = neg ? (~sum + SW'(1)) : sum;
    prod = PW'(mag) * PW'(g);
    p    = prod[GAIN_FRAC_BITS +: SW];
    c.over = neg ? (p > NEG_LIMIT) : (p >= NEG_LIMIT);
    if (c.over) begin
      c.value = neg ? mal_pkg::OUT_MIN : mal_pkg::OUT_MAX;
    end else begin
      c.value = neg ? (~p[OW-1:0] + OW'(1)) : p[OW-1:0];
    end
    return c;
  endfunction

  function automatic logic [GW-1:0] adapt(
    input logic [GW-1:0] g,
    input logic          over,
    input mal_pkg::cfg_t cfg
  );
    logic [AW-1:0] ge, fl, raised;
    logic [GW-1:0] r;
    ge     = AW'(g);
    fl     = AW'(cfg.gain_floor);
    raised = ge + AW'(cfg.gain_rise_step);
    r      = g;
    if (over) begin
      if (ge > fl) begin
        r = (g > GAIN_DROP) ? g - GAIN_DROP : '0;
      end
    end else if (g < GAIN_UNITY) begin
      r = (raised > AW'(GAIN_UNITY)) ? GAIN_UNITY : raised[GW-1:0];
    end
    return r;
  endfunction

  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  // both channels scale with the gain from before this frame
  assign left_c   = scale_clamp(q_data_i.left_sum, gain_q);
  assign right_c  = scale_clamp(q_data_i.right_sum, gain_q);
  assign gain_mid = adapt(gain_q, left_c.over, cfg_i);
  assign gain_d   = pop_o ? adapt(gain_mid, right_c.over, cfg_i) : gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= GAIN_UNITY;
      out_valid_q <= 1'b0;
    end else begin
      gain_q <= gain_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      left_q  <= left_c.value;
      right_q <= right_c.value;
      clip_q  <= left_c.over || right_c.over;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;
  assign clipped_o   = clip_q;

endmodule

### rtl/core/mal_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the mix accumulator with adaptive limiter, bound to the top.
// Depends on mal_pkg for port widths and output limits.
module mal_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [mal_pkg::OUT_W-1:0]  left_out_o,
  input logic signed [mal_pkg::OUT_W-1:0]  right_out_o,
  input logic                              clipped_o,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(left_out_o) && $stable(right_out_o) && $stable(clipped_o))
    else $error("output result changed while stalled");

  // A clamped result sits on a rail in at least one channel
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |->
      (left_out_o == mal_pkg::OUT_MAX) || (left_out_o == mal_pkg::OUT_MIN) ||
      (right_out_o == mal_pkg::OUT_MAX) || (right_out_o == mal_pkg::OUT_MIN))
    else $error("clipped set without a clamped sample");

  // Backpressure on the input only comes from a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // Configuration writes never stall
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind mix_accumulate_adaptive_limiter mal_checker u_mal_checker (.*);
